FILE: rtl/core/fsmpq_pkg.sv
// Shared types and constants of the arrival-ordered min priority queue.
// No dependencies; imported by the controller, datapath and top level.
package fsmpq_pkg;

   // Queue geometry and field widths
   localparam int CAPACITY     = 8;
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int STATUS_W     = 2;

   // Minimum-search tree geometry: levels and leaf count padded to a power of two
   localparam int TREE_LVLS = (IDX_W < 1) ? 1 : IDX_W;
   localparam int TREE_PAD  = 1 << TREE_LVLS;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((STATUS_W + KEY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8;

   // Request kind carried on tuser
   typedef enum logic {
      ACT_INSERT  = 1'b0,
      ACT_EXTRACT = 1'b1
   } action_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_EXTRACTED = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;    // capture a new request
      logic latch_best;  // register the oldest-minimum position
      logic commit;      // update storage and load the response
   } cmd_type;

endpackage

FILE: rtl/core/fsmpq_ctrl.sv
// Sequencer of the priority queue: accept, search, update, response valid.
// Depends on fsmpq_pkg; drives the datapath through cmd_type.
module fsmpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output fsmpq_pkg::cmd_type cmd
);
   import fsmpq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;
   logic      accept;

   // update finishes once the response slot is free
   assign commit     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) || commit;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load_req   = accept;
   assign cmd.latch_best = (state_ff == ST_SEARCH);
   assign cmd.commit     = commit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) state_in = accept ? ST_SEARCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      priority if (commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an accepted request always enters the search cycle
   a_accept_to_search: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SEARCH)
      else $error("accepted request did not start a search");

   // search is always followed by update
   a_search_to_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |=> state_ff == ST_UPDATE)
      else $error("search did not move to update");

   // a commit always leaves a response on the output
   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("commit without response");

endmodule

FILE: rtl/core/fsmpq_dp.sv
// Datapath of the priority queue: arrival-ordered entry registers, minimum
// search tree, shift/append update and response register. Uses fsmpq_pkg.
module fsmpq_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  fsmpq_pkg::cmd_type                 cmd,
   input  logic                               req_action,
   input  logic [fsmpq_pkg::KEY_BITS-1:0]     req_key,
   input  logic [fsmpq_pkg::PAYLOAD_BITS-1:0] req_payload,
   output logic [fsmpq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fsmpq_pkg::KEY_BITS-1:0]     rsp_out_key,
   output logic [fsmpq_pkg::PAYLOAD_BITS-1:0] rsp_out_payload,
   output logic [fsmpq_pkg::CNT_W-1:0]        rsp_occupancy
);
   import fsmpq_pkg::*;

   // captured request
   logic                    req_action_ff;
   logic [KEY_BITS-1:0]     req_key_ff;
   logic [PAYLOAD_BITS-1:0] req_payload_ff;

   // entries, position 0 holds the oldest
   logic [KEY_BITS-1:0]     key_ff [CAPACITY];
   logic [KEY_BITS-1:0]     key_in [CAPACITY];
   logic [PAYLOAD_BITS-1:0] pay_ff [CAPACITY];
   logic [PAYLOAD_BITS-1:0] pay_in [CAPACITY];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        best_ff;

   // response register
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0]        rsp_occ_ff;

   // minimum search tree
   logic [KEY_BITS-1:0] t_key [TREE_LVLS+1][TREE_PAD];
   logic [IDX_W-1:0]    t_idx [TREE_LVLS+1][TREE_PAD];
   logic                t_vld [TREE_LVLS+1][TREE_PAD];

   logic full;
   logic empty;
   logic is_extract;

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign is_extract = (req_action_ff == ACT_EXTRACT);

   // pairwise tree; the left (older) leaf wins on equal keys
   always_comb begin
      for (int l = 0; l <= TREE_LVLS; l++) begin
         for (int n = 0; n < TREE_PAD; n++) begin
            t_key[l][n] = '0;
            t_idx[l][n] = '0;
            t_vld[l][n] = 1'b0;
         end
      end
      for (int n = 0; n < CAPACITY; n++) begin
         t_key[0][n] = key_ff[n];
         t_idx[0][n] = IDX_W'(n);
         t_vld[0][n] = (CNT_W'(n) < count_ff);
      end
      for (int l = 0; l < TREE_LVLS; l++) begin
         for (int n = 0; n < (TREE_PAD >> (l + 1)); n++) begin
            if (t_vld[l][2*n+1] &&
                (!t_vld[l][2*n] || (t_key[l][2*n+1] < t_key[l][2*n]))) begin
               t_key[l+1][n] = t_key[l][2*n+1];
               t_idx[l+1][n] = t_idx[l][2*n+1];
            end else begin
               t_key[l+1][n] = t_key[l][2*n];
               t_idx[l+1][n] = t_idx[l][2*n];
            end
            t_vld[l+1][n] = t_vld[l][2*n] || t_vld[l][2*n+1];
         end
      end
   end

   // storage update and response values
   always_comb begin
      key_in        = key_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      rsp_status_in = ST_INSERTED;
      rsp_key_in    = '0;
      rsp_pay_in    = '0;
      if (!is_extract) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            key_in[count_ff[IDX_W-1:0]] = req_key_ff;
            pay_in[count_ff[IDX_W-1:0]] = req_payload_ff;
            count_in                    = count_ff + 1'b1;
         end
      end else if (empty) begin
         rsp_status_in = ST_EMPTY;
      end else begin
         rsp_status_in = ST_EXTRACTED;
         rsp_key_in    = key_ff[best_ff];
         rsp_pay_in    = pay_ff[best_ff];
         // entries behind the removed one close the gap
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= best_ff) begin
               key_in[i] = key_ff[i+1];
               pay_in[i] = pay_ff[i+1];
            end
         end
         count_in = count_ff - 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_action_ff  <= req_action;
         req_key_ff     <= req_key;
         req_payload_ff <= req_payload;
      end
      if (cmd.latch_best) begin
         best_ff <= t_idx[TREE_LVLS][0];
      end
      if (cmd.commit) begin
         key_ff        <= key_in;
         pay_ff        <= pay_in;
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_occupancy   = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_extract_count: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_extract && !empty |=> count_ff == $past(count_ff) - 1'b1)
      else $error("extract did not drop the count by one");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_occ_ff == count_ff)
      else $error("reported occupancy differs from entry count");

endmodule

FILE: rtl/core/fifo_stable_min_priority_queue.sv
// Top level of the arrival-ordered min priority queue (stream in, stream out).
// Depends on fsmpq_pkg, fsmpq_ctrl and fsmpq_dp.
//
//   channel | dir | tdata (low bit first)              | tuser
//   req     | in  | key, payload (48 bits)             | action
//   rsp     | out | status, out_key, out_payload,      | -
//           |     | occupancy, zero pad (56 bits)      |
//
// Every request gives one response, registered when the update commits: the search
// state latches the minimum-search compare tree result, the update state does the
// shift/append update. The next request is taken as the update commits.
// Reset clears the entry count; entry storage is not cleared.
// A response not taken holds the update, which then holds req_tready low.
module fifo_stable_min_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fsmpq_pkg::REQ_DATA_W-1:0] req_tdata,  // key, payload
   input  logic                             req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fsmpq_pkg::RSP_DATA_W-1:0] rsp_tdata   // status, out_key, out_payload, occupancy
);
   import fsmpq_pkg::*;

   cmd_type                 cmd;
   logic [STATUS_W-1:0]     rsp_status;
   logic [KEY_BITS-1:0]     rsp_out_key;
   logic [PAYLOAD_BITS-1:0] rsp_out_payload;
   logic [CNT_W-1:0]        rsp_occupancy;

   fsmpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fsmpq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_tuser),
      .req_key         (req_tdata[KEY_BITS-1:0]),
      .req_payload     (req_tdata[KEY_BITS +: PAYLOAD_BITS]),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_occupancy   (rsp_occupancy)
   );

   // pack response fields, zero filled to whole bytes
   assign rsp_tdata = RSP_DATA_W'({rsp_occupancy, rsp_out_payload, rsp_out_key, rsp_status});

endmodule
